FILE: sv/rcl_pkg.sv
// Shared types, constants, microprogram and arithmetic helpers for the RC ladder step block.
package rcl_pkg;

    localparam int MAX_SUB_STEPS = 16;
    localparam int SUB_W = $clog2(MAX_SUB_STEPS + 1);
    localparam int STEP_W = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_END_DISTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_STEPS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_R_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_R_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND  = 3'd6;

    // Program addresses that the sequencer or the program itself names.
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SUB  = 4'd4;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [31:0]        U32_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] interface_flow;
        logic signed [31:0] outlet_pressure;
        logic [30:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pressure_first;
        logic signed [31:0] pressure_second;
        logic               saturated;
    } t_out_item;

    // Operation issued to the shared multiplier.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HG0,
        OP_HG1,
        OP_Q0,
        OP_Q1,
        OP_P0,
        OP_P1
    } t_op;

    typedef enum logic [1:0] {
        CTL_WAIT,
        CTL_NEXT,
        CTL_LOOP,
        CTL_DONE
    } t_ctl;

    typedef struct packed {
        t_op               op;
        t_ctl              ctl;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load_out;
        logic busy;
    } t_seq_ctl;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } t_sat;

    // Microprogram. The multiplier's operand, product and write-back registers lie between an issue and its
    // write-back, so the empty steps wait for the values that the next issue reads.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NONE, ctl: CTL_NEXT, target: STEP_IDLE};
        case (step)
            4'd0:  w.ctl = CTL_WAIT;
            4'd1:  w.op = OP_HG0;
            4'd2:  w.op = OP_HG1;
            4'd3:  w.op = OP_NONE;
            4'd4:  w.op = OP_Q0;
            4'd5:  w.op = OP_Q1;
            4'd6:  w.op = OP_NONE;
            4'd7:  w.op = OP_P0;
            4'd8:  w.op = OP_P1;
            4'd9:  w.op = OP_NONE;
            4'd10: begin
                w.ctl = CTL_LOOP;
                w.target = STEP_SUB;
            end
            4'd11: w.ctl = CTL_DONE;
            default: w.ctl = CTL_DONE;
        endcase
        return w;
    endfunction

    // Clamp a 50-bit signed value to the signed 32-bit range.
    function automatic t_sat sat32(input logic signed [49:0] v);
        t_sat r;
        r.clip = !((&v[49:31]) || !(|v[49:31]));
        if (!r.clip) begin
            r.value = v[31:0];
        end else if (v[49]) begin
            r.value = S32_MIN;
        end else begin
            r.value = S32_MAX;
        end
        return r;
    endfunction

endpackage

FILE: sv/rcl_seq.sv
// Microcode sequencer: step counter, sub-step loop counter and program ROM decode.
module rcl_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_out_free,
    input  logic [rcl_pkg::SUB_W-1:0] i_subs,
    output rcl_pkg::t_seq_ctl         o_ctl
);

    logic [rcl_pkg::STEP_W-1:0] r_step;
    logic [rcl_pkg::STEP_W-1:0] n_step;
    logic [rcl_pkg::SUB_W-1:0]  r_cnt;
    logic [rcl_pkg::SUB_W-1:0]  n_cnt;
    rcl_pkg::t_uword            uw;

    assign uw = rcl_pkg::ucode(r_step);

    always_comb begin
        n_step = r_step;
        n_cnt = r_cnt;
        o_ctl.op = uw.op;
        o_ctl.load_out = 1'b0;
        o_ctl.busy = 1'b1;
        unique case (uw.ctl)
            rcl_pkg::CTL_WAIT: begin
                o_ctl.busy = 1'b0;
                if (i_start) begin
                    n_step = r_step + 1'b1;
                    n_cnt = i_subs;
                end
            end
            rcl_pkg::CTL_NEXT: begin
                n_step = r_step + 1'b1;
            end
            rcl_pkg::CTL_LOOP: begin
                if (r_cnt > rcl_pkg::SUB_W'(1)) begin
                    n_step = uw.target;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rcl_pkg::CTL_DONE: begin
                // The result waits here until the output register is free.
                if (i_out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_step = rcl_pkg::STEP_IDLE;
                end
            end
            default: n_step = rcl_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rcl_pkg::STEP_IDLE;
            r_cnt <= '0;
        end else begin
            r_step <= n_step;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/rc_ladder_windkessel_step.sv
// A new request is taken only once the sequencer is idle and the last result is in the output register;
// each of the S sub-steps (S = clamped sub-step count) is four dependent passes
// through the one shared 32x32 multiplier, whose issue-multiply-writeback path is 3 deep.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) restores the register defaults, zero pressures,
// an idle sequencer and an empty output register.
module rc_ladder_windkessel_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rcl_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rcl_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    // Configuration registers. The start pressure only matters when it is written,
    // so it goes straight into the compartments.
    logic               r_distal;
    logic [4:0]         r_subs_cfg;
    logic [31:0]        r_inv_r0;
    logic [31:0]        r_inv_r1;
    logic [31:0]        r_gain0;
    logic [31:0]        r_gain1;

    // Model state and per-request working values.
    logic signed [31:0] r_p0;
    logic signed [31:0] r_p1;
    logic signed [31:0] r_qin;
    logic signed [31:0] r_pout;
    logic [30:0]        r_dt;
    logic [31:0]        r_hg0;
    logic [31:0]        r_hg1;
    logic signed [31:0] r_q0;
    logic signed [31:0] r_q1;
    logic               r_sat;

    // Multiplier pipeline.
    logic [31:0]        r_mag;
    logic [31:0]        r_coef;
    logic               r_neg;
    rcl_pkg::t_op       r_tag1;
    logic [63:0]        r_prod;
    logic               r_pneg;
    rcl_pkg::t_op       r_tag2;

    logic               r_out_valid;
    rcl_pkg::t_out_item r_out;

    logic                      in_accept;
    logic                      cfg_write;
    logic                      out_free;
    logic [rcl_pkg::SUB_W-1:0] subs_eff;
    rcl_pkg::t_seq_ctl         seq;
    rcl_pkg::t_sat             qneg;
    logic signed [32:0]        opnd;
    logic [31:0]               coef;
    logic [32:0]               opnd_neg;
    logic signed [64:0]        sprod;
    logic signed [48:0]        shifted;
    logic signed [31:0]        p_sel;
    logic signed [49:0]        p_sum;
    rcl_pkg::t_sat             wb_q;
    rcl_pkg::t_sat             wb_p;
    logic [31:0]               wb_hg;
    logic                      wb_hg_clip;
    logic                      wb_clip;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = seq.busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        if (r_subs_cfg == '0) begin
            subs_eff = rcl_pkg::SUB_W'(1);
        end else if (int'(r_subs_cfg) > rcl_pkg::MAX_SUB_STEPS) begin
            subs_eff = rcl_pkg::SUB_W'(rcl_pkg::MAX_SUB_STEPS);
        end else begin
            subs_eff = rcl_pkg::SUB_W'(r_subs_cfg);
        end
    end

    rcl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_out_free (out_free),
        .i_subs     (subs_eff),
        .o_ctl      (seq)
    );

    // Proximal coupling negates the interface flow; only the most negative value clips.
    assign qneg = rcl_pkg::sat32(-{{18{i_in_data.interface_flow[31]}},
                                   i_in_data.interface_flow});

    // Operand selection for the issued operation; the operand is registered in sign-magnitude form.
    always_comb begin
        opnd = '0;
        coef = '0;
        case (seq.op)
            rcl_pkg::OP_HG0: begin
                opnd = {2'b00, r_dt};
                coef = r_gain0;
            end
            rcl_pkg::OP_HG1: begin
                opnd = {2'b00, r_dt};
                coef = r_gain1;
            end
            rcl_pkg::OP_Q0: begin
                opnd = {r_p0[31], r_p0} - {r_p1[31], r_p1};
                coef = r_inv_r0;
            end
            rcl_pkg::OP_Q1: begin
                opnd = {r_p1[31], r_p1} - {r_pout[31], r_pout};
                coef = r_inv_r1;
            end
            rcl_pkg::OP_P0: begin
                opnd = {r_qin[31], r_qin} - {r_q0[31], r_q0};
                coef = r_hg0;
            end
            rcl_pkg::OP_P1: begin
                opnd = {r_q0[31], r_q0} - {r_q1[31], r_q1};
                coef = r_hg1;
            end
            default: begin
                opnd = '0;
                coef = '0;
            end
        endcase
        opnd_neg = -opnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= rcl_pkg::OP_NONE;
            r_tag2 <= rcl_pkg::OP_NONE;
        end else begin
            r_tag1 <= seq.op;
            r_tag2 <= r_tag1;
        end
        r_neg <= opnd[32];
        r_mag <= opnd[32] ? opnd_neg[31:0] : opnd[31:0];
        r_coef <= coef;
        r_prod <= r_mag * r_coef;
        r_pneg <= r_neg;
    end

    // Write-back: product / 2^16, rounded toward minus infinity, plus pressure for P, then clamped.
    always_comb begin
        sprod = r_pneg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        shifted = sprod[64:16];
        wb_q = rcl_pkg::sat32({shifted[48], shifted});
        p_sel = (r_tag2 == rcl_pkg::OP_P0) ? r_p0 : r_p1;
        p_sum = {{18{p_sel[31]}}, p_sel} + {shifted[48], shifted};
        wb_p = rcl_pkg::sat32(p_sum);
        wb_hg_clip = |r_prod[63:48];
        wb_hg = wb_hg_clip ? rcl_pkg::U32_MAX : r_prod[47:16];
        case (r_tag2) inside
            rcl_pkg::OP_HG0, rcl_pkg::OP_HG1: wb_clip = wb_hg_clip;
            rcl_pkg::OP_Q0, rcl_pkg::OP_Q1:   wb_clip = wb_q.clip;
            rcl_pkg::OP_P0, rcl_pkg::OP_P1:   wb_clip = wb_p.clip;
            default:                          wb_clip = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_tag2)
            rcl_pkg::OP_HG0: r_hg0 <= wb_hg;
            rcl_pkg::OP_HG1: r_hg1 <= wb_hg;
            rcl_pkg::OP_Q0:  r_q0 <= wb_q.value;
            rcl_pkg::OP_Q1:  r_q1 <= wb_q.value;
            default: begin
            end
        endcase
        if (in_accept) begin
            r_qin <= r_distal ? i_in_data.interface_flow : qneg.value;
            r_pout <= i_in_data.outlet_pressure;
            r_dt <= i_in_data.time_step;
        end
    end

    // Configuration, pressures and the clamp flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distal <= 1'b1;
            r_subs_cfg <= 5'd1;
            r_inv_r0 <= 32'h0001_0000;
            r_inv_r1 <= 32'h0001_0000;
            r_gain0 <= 32'h0001_0000;
            r_gain1 <= 32'h0001_0000;
            r_p0 <= '0;
            r_p1 <= '0;
            r_sat <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (i_cfg_index)
                    rcl_pkg::REG_END_DISTAL:   r_distal <= i_cfg_data[0];
                    rcl_pkg::REG_SUB_STEPS:    r_subs_cfg <= i_cfg_data[4:0];
                    rcl_pkg::REG_INIT_PRESS: begin
                        r_p0 <= i_cfg_data;
                        r_p1 <= i_cfg_data;
                    end
                    rcl_pkg::REG_INV_R_FIRST:  r_inv_r0 <= i_cfg_data;
                    rcl_pkg::REG_INV_R_SECOND: r_inv_r1 <= i_cfg_data;
                    rcl_pkg::REG_GAIN_FIRST:   r_gain0 <= i_cfg_data;
                    rcl_pkg::REG_GAIN_SECOND:  r_gain1 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_tag2 == rcl_pkg::OP_P0) begin
                r_p0 <= wb_p.value;
            end
            if (r_tag2 == rcl_pkg::OP_P1) begin
                r_p1 <= wb_p.value;
            end
            if (in_accept) begin
                r_sat <= !r_distal && qneg.clip;
            end else if (wb_clip) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (seq.load_out) begin
            r_out.pressure_first <= r_p0;
            r_out.pressure_second <= r_p1;
            r_out.saturated <= r_sat;
        end
    end

endmodule

FILE: sv/rcl_checker.sv
// Port-level checker for the RC ladder step block and its bind statement.
module rcl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input rcl_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input rcl_pkg::t_out_item            o_out_data
);

    // Once a request is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after a request was taken");

    // A result never appears in the cycle after its request.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Handing over a result returns the sequencer to idle in the same cycle.
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("block still busy when its result appeared");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A stalled request stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled request changed");

endmodule

bind rc_ladder_windkessel_step rcl_checker u_rcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
